>>> src/srcht_pkg.sv
// shared constants for the swept ray circle hit test
package srcht_pkg;

    // quotient bits kept by each root divider; higher bits only signal overflow
    localparam int QUOT_BITS = 33;
    localparam int ROOT_W    = 32;

    localparam logic signed [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic signed [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

endpackage

>>> src/swept_ray_circle_hit_test_core.sv
// swept ray against circle hit test, fully pipelined
//
// One item per clock while the output is accepted. The pipeline forms a = d.d,
// h = d.(P-C), c = |P-C|^2 - r^2 and the discriminant h*h - a*c with split
// multipliers, takes the square root one root bit per stage (2*COORD_WIDTH+1
// stages), forms and aligns the two root numerators, runs 33 restoring
// division stages side by side for both roots, then a saturation stage and
// the window compare with the output register. The whole pipeline holds while a
// result waits unaccepted and moves again as soon as it is taken. Roots are
// floor-rounded, saturated to signed 32 bits with TIME_FRAC_BITS fraction bits;
// zero direction or a negative discriminant gives has_roots = 0, hit = 0 and
// both roots zero.
module swept_ray_circle_hit_test_core #(
    parameter int COORD_WIDTH    = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // origin_x, origin_y, dir_x, dir_y, centre_x, centre_y, radius,
    // window_start, window_end, zero pad
    input  logic [((7*COORD_WIDTH+22+2*TIME_FRAC_BITS)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // hit, has_roots, t_near, t_far, zero pad
    output logic [((2+2*srcht_pkg::ROOT_W+7)/8)*8-1:0] o_m_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int TF    = TIME_FRAC_BITS;
    localparam int WW    = 8 + TF;
    localparam int RW    = srcht_pkg::ROOT_W;
    localparam int QB    = srcht_pkg::QUOT_BITS;
    localparam int OUT_W = ((2 + 2*RW + 7) / 8) * 8;

    localparam int PW   = CW + 1;        // P - C
    localparam int AW   = 2 * CW;        // a, unsigned
    localparam int HW   = 2 * CW + 2;    // h, signed
    localparam int HMW  = HW - 1;        // |h|
    localparam int CCW  = 2 * CW + 3;    // c, signed
    localparam int CMW  = CCW - 1;       // |c|
    localparam int HL   = (HMW + 1) / 2;
    localparam int HH   = HMW - HL;
    localparam int AL   = AW / 2;
    localparam int AH   = AW - AL;
    localparam int CL   = (CMW + 1) / 2;
    localparam int CH   = CMW - CL;
    localparam int H2W  = 2 * HMW;
    localparam int PRW  = AW + CMW;
    localparam int DW   = 4 * CW + 3;    // discriminant, signed
    localparam int SW   = 2 * CW + 1;    // square root
    localparam int NW   = 2 * CW + 3;    // root numerator, signed
    localparam int MSW  = NW + TF;       // aligned numerator magnitude
    localparam int TW   = MSW - QB;
    localparam int CPW  = (TW > AW) ? TW : AW;

    logic en;
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- stage 1: unpack, center offset
    logic signed [CW-1:0] in_ox, in_oy, in_dx, in_dy, in_cx, in_cy;
    logic [CW-2:0] in_rad;
    logic [WW-1:0] in_ws, in_we;
    assign in_ox  = i_s_tdata[0*CW +: CW];
    assign in_oy  = i_s_tdata[1*CW +: CW];
    assign in_dx  = i_s_tdata[2*CW +: CW];
    assign in_dy  = i_s_tdata[3*CW +: CW];
    assign in_cx  = i_s_tdata[4*CW +: CW];
    assign in_cy  = i_s_tdata[5*CW +: CW];
    assign in_rad = i_s_tdata[6*CW +: CW-1];
    assign in_ws  = i_s_tdata[7*CW-1 +: WW];
    assign in_we  = i_s_tdata[7*CW-1+WW +: WW];

    logic r1_vld, r1_dz;
    logic signed [CW-1:0] r1_dx, r1_dy;
    logic signed [PW-1:0] r1_px, r1_py, n1_px, n1_py;
    logic [CW-2:0] r1_rad;
    logic [WW-1:0] r1_ws, r1_we;

    assign n1_px = PW'(in_ox) - PW'(in_cx);
    assign n1_py = PW'(in_oy) - PW'(in_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dz  <= (in_dx == '0) && (in_dy == '0);
            r1_dx  <= in_dx;
            r1_dy  <= in_dy;
            r1_px  <= n1_px;
            r1_py  <= n1_py;
            r1_rad <= in_rad;
            r1_ws  <= in_ws;
            r1_we  <= in_we;
        end
    end

    // ---------------- stage 2: products
    logic r2_vld, r2_dz;
    logic signed [2*CW-1:0] r2_dxx, r2_dyy, n2_dxx, n2_dyy;
    logic signed [2*CW:0] r2_dxp, r2_dyp, n2_dxp, n2_dyp;
    logic signed [2*PW-1:0] r2_pxx, r2_pyy, n2_pxx, n2_pyy;
    logic [2*CW-3:0] r2_rr, n2_rr;
    logic [WW-1:0] r2_ws, r2_we;

    assign n2_dxx = r1_dx * r1_dx;
    assign n2_dyy = r1_dy * r1_dy;
    assign n2_dxp = (2*CW+1)'(r1_dx) * (2*CW+1)'(r1_px);
    assign n2_dyp = (2*CW+1)'(r1_dy) * (2*CW+1)'(r1_py);
    assign n2_pxx = r1_px * r1_px;
    assign n2_pyy = r1_py * r1_py;
    assign n2_rr  = r1_rad * r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dz  <= r1_dz;
            r2_dxx <= n2_dxx;
            r2_dyy <= n2_dyy;
            r2_dxp <= n2_dxp;
            r2_dyp <= n2_dyp;
            r2_pxx <= n2_pxx;
            r2_pyy <= n2_pyy;
            r2_rr  <= n2_rr;
            r2_ws  <= r1_ws;
            r2_we  <= r1_we;
        end
    end

    // ---------------- stage 3: a, h, c
    logic r3_vld, r3_dz;
    logic [AW-1:0] r3_a, n3_a;
    logic signed [HW-1:0] r3_h, n3_h;
    logic signed [CCW-1:0] r3_c, n3_c;
    logic [WW-1:0] r3_ws, r3_we;

    assign n3_a = AW'($unsigned(r2_dxx)) + AW'($unsigned(r2_dyy));
    assign n3_h = HW'(r2_dxp) + HW'(r2_dyp);
    assign n3_c = CCW'(r2_pxx) + CCW'(r2_pyy) - CCW'(signed'({1'b0, r2_rr}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dz <= r2_dz;
            r3_a  <= n3_a;
            r3_h  <= n3_h;
            r3_c  <= n3_c;
            r3_ws <= r2_ws;
            r3_we <= r2_we;
        end
    end

    // ---------------- stage 4: magnitudes for the wide products
    logic r4_vld, r4_dz, r4_cn;
    logic [AW-1:0] r4_a;
    logic signed [HW-1:0] r4_h;
    logic [HMW-1:0] r4_hm, n4_hm;
    logic [CMW-1:0] r4_cm, n4_cm;
    logic [WW-1:0] r4_ws, r4_we;

    assign n4_hm = r3_h[HW-1] ? HMW'(-r3_h) : HMW'(r3_h);
    assign n4_cm = r3_c[CCW-1] ? CMW'(-r3_c) : CMW'(r3_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dz <= r3_dz;
            r4_cn <= r3_c[CCW-1];
            r4_a  <= r3_a;
            r4_h  <= r3_h;
            r4_hm <= n4_hm;
            r4_cm <= n4_cm;
            r4_ws <= r3_ws;
            r4_we <= r3_we;
        end
    end

    // ---------------- stage 5: partial products of h*h and a*|c|
    logic r5_vld, r5_dz, r5_cn;
    logic [AW-1:0] r5_a;
    logic signed [HW-1:0] r5_h;
    logic [2*HL-1:0] r5_hll;
    logic [2*HH-1:0] r5_hhh;
    logic [HL+HH-1:0] r5_hlh;
    logic [AL+CL-1:0] r5_alcl;
    logic [AL+CH-1:0] r5_alch;
    logic [AH+CL-1:0] r5_ahcl;
    logic [AH+CH-1:0] r5_ahch;
    logic [WW-1:0] r5_ws, r5_we;

    logic [HL-1:0] hm_lo;
    logic [HH-1:0] hm_hi;
    logic [AL-1:0] a_lo;
    logic [AH-1:0] a_hi;
    logic [CL-1:0] cm_lo;
    logic [CH-1:0] cm_hi;
    assign hm_lo = r4_hm[HL-1:0];
    assign hm_hi = r4_hm[HMW-1:HL];
    assign a_lo  = r4_a[AL-1:0];
    assign a_hi  = r4_a[AW-1:AL];
    assign cm_lo = r4_cm[CL-1:0];
    assign cm_hi = r4_cm[CMW-1:CL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dz   <= r4_dz;
            r5_cn   <= r4_cn;
            r5_a    <= r4_a;
            r5_h    <= r4_h;
            r5_hll  <= (2*HL)'(hm_lo) * (2*HL)'(hm_lo);
            r5_hhh  <= (2*HH)'(hm_hi) * (2*HH)'(hm_hi);
            r5_hlh  <= (HL+HH)'(hm_lo) * (HL+HH)'(hm_hi);
            r5_alcl <= (AL+CL)'(a_lo) * (AL+CL)'(cm_lo);
            r5_alch <= (AL+CH)'(a_lo) * (AL+CH)'(cm_hi);
            r5_ahcl <= (AH+CL)'(a_hi) * (AH+CL)'(cm_lo);
            r5_ahch <= (AH+CH)'(a_hi) * (AH+CH)'(cm_hi);
            r5_ws   <= r4_ws;
            r5_we   <= r4_we;
        end
    end

    // ---------------- stage 6: recombine h*h and a*|c|
    logic r6_vld, r6_dz, r6_cn;
    logic [AW-1:0] r6_a;
    logic signed [HW-1:0] r6_h;
    logic [H2W-1:0] r6_h2, n6_h2;
    logic [PRW-1:0] r6_ac, n6_ac;
    logic [WW-1:0] r6_ws, r6_we;

    assign n6_h2 = (H2W'(r5_hhh) << (2*HL)) + (H2W'(r5_hlh) << (HL+1)) + H2W'(r5_hll);
    assign n6_ac = (PRW'(r5_ahch) << (AL+CL)) + (PRW'(r5_ahcl) << AL)
                 + (PRW'(r5_alch) << CL) + PRW'(r5_alcl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_dz <= r5_dz;
            r6_cn <= r5_cn;
            r6_a  <= r5_a;
            r6_h  <= r5_h;
            r6_h2 <= n6_h2;
            r6_ac <= n6_ac;
            r6_ws <= r5_ws;
            r6_we <= r5_we;
        end
    end

    // ---------------- stage 7: discriminant, feeds the square root
    logic signed [DW-1:0] n7_disc;
    logic n7_hr;

    always_comb begin
        if (r6_cn) begin
            n7_disc = signed'(DW'(r6_h2)) + signed'(DW'(r6_ac));
        end else begin
            n7_disc = signed'(DW'(r6_h2)) - signed'(DW'(r6_ac));
        end
        n7_hr = !r6_dz && !n7_disc[DW-1];
    end

    // square root, one root bit per stage
    logic           r_sq_vld  [0:SW];
    logic           r_sq_hr   [0:SW];
    logic [2*SW-1:0] r_sq_x   [0:SW];
    logic [SW+1:0]  r_sq_rem  [0:SW];
    logic [SW-1:0]  r_sq_root [0:SW];
    logic [AW-1:0]  r_sq_a    [0:SW];
    logic signed [HW-1:0] r_sq_h [0:SW];
    logic [WW-1:0]  r_sq_ws   [0:SW];
    logic [WW-1:0]  r_sq_we   [0:SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_hr[0]   <= n7_hr;
            r_sq_x[0]    <= n7_disc[2*SW-1:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_a[0]    <= r6_a;
            r_sq_h[0]    <= r6_h;
            r_sq_ws[0]   <= r6_ws;
            r_sq_we[0]   <= r6_we;
        end
    end

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        localparam int BI = SW - 1 - k;
        logic [SW+1:0] n_try, n_trial, n_rem;
        logic n_ge;

        assign n_try   = {r_sq_rem[k][SW-1:0], r_sq_x[k][2*BI+1 -: 2]};
        assign n_trial = {r_sq_root[k], 2'b01};
        assign n_ge    = n_try >= n_trial;
        assign n_rem   = n_ge ? (n_try - n_trial) : n_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_hr[k+1]   <= r_sq_hr[k];
                r_sq_x[k+1]    <= r_sq_x[k];
                r_sq_rem[k+1]  <= n_rem;
                r_sq_root[k+1] <= {r_sq_root[k][SW-2:0], n_ge};
                r_sq_a[k+1]    <= r_sq_a[k];
                r_sq_h[k+1]    <= r_sq_h[k];
                r_sq_ws[k+1]   <= r_sq_ws[k];
                r_sq_we[k+1]   <= r_sq_we[k];
            end
        end
    end

    // ---------------- stage 8: root numerators -h -/+ s
    logic r8_vld, r8_hr;
    logic [AW-1:0] r8_a;
    logic signed [NW-1:0] r8_num [0:1];
    logic signed [NW-1:0] n8_nh, n8_s;
    logic [WW-1:0] r8_ws, r8_we;

    assign n8_nh = -NW'(r_sq_h[SW]);
    assign n8_s  = NW'(signed'({1'b0, r_sq_root[SW]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r_sq_vld[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_hr     <= r_sq_hr[SW];
            r8_a      <= r_sq_a[SW];
            r8_num[0] <= n8_nh - n8_s;
            r8_num[1] <= n8_nh + n8_s;
            r8_ws     <= r_sq_ws[SW];
            r8_we     <= r_sq_we[SW];
        end
    end

    // ---------------- stage 9: sign and magnitude
    logic r9_vld, r9_hr;
    logic [AW-1:0] r9_a;
    logic r9_neg [0:1];
    logic [NW-1:0] r9_mag [0:1];
    logic [WW-1:0] r9_ws, r9_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_hr <= r8_hr;
            r9_a  <= r8_a;
            r9_ws <= r8_ws;
            r9_we <= r8_we;
            for (int g = 0; g < 2; g++) begin
                r9_neg[g] <= r8_num[g][NW-1];
                r9_mag[g] <= r8_num[g][NW-1] ? NW'(-r8_num[g]) : NW'(r8_num[g]);
            end
        end
    end

    // ---------------- restoring division of both roots by a
    logic          r_dv_vld [0:QB];
    logic          r_dv_hr  [0:QB];
    logic [AW-1:0] r_dv_a   [0:QB];
    logic [WW-1:0] r_dv_ws  [0:QB];
    logic [WW-1:0] r_dv_we  [0:QB];
    logic          r_dv_neg [0:1][0:QB];
    logic          r_dv_ovf [0:1][0:QB];
    logic [AW-1:0] r_dv_rem [0:1][0:QB];
    logic [QB-1:0] r_dv_q   [0:1][0:QB];
    logic [QB-1:0] r_dv_low [0:1][0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_hr[0] <= r9_hr;
            r_dv_a[0]  <= r9_a;
            r_dv_ws[0] <= r9_ws;
            r_dv_we[0] <= r9_we;
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_root
        logic [MSW-1:0] n_msh;
        logic [TW-1:0]  n_top;

        assign n_msh = {r9_mag[g], {TF{1'b0}}};
        assign n_top = n_msh[MSW-1:QB];

        // quotient at or above 2^QB saturates whatever the low bits
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_neg[g][0] <= r9_neg[g];
                r_dv_ovf[g][0] <= CPW'(n_top) >= CPW'(r9_a);
                r_dv_rem[g][0] <= AW'(n_top);
                r_dv_q[g][0]   <= '0;
                r_dv_low[g][0] <= n_msh[QB-1:0];
            end
        end

        for (genvar k = 0; k < QB; k++) begin : g_step
            logic [AW:0] n_try;
            logic n_ge;

            assign n_try = {r_dv_rem[g][k], r_dv_low[g][k][QB-1-k]};
            assign n_ge  = n_try >= {1'b0, r_dv_a[k]};

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_neg[g][k+1] <= r_dv_neg[g][k];
                    r_dv_ovf[g][k+1] <= r_dv_ovf[g][k];
                    r_dv_rem[g][k+1] <= n_ge ? AW'(n_try - {1'b0, r_dv_a[k]}) : AW'(n_try);
                    r_dv_q[g][k+1]   <= {r_dv_q[g][k][QB-2:0], n_ge};
                    r_dv_low[g][k+1] <= r_dv_low[g][k];
                end
            end
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_dv_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_hr[k+1] <= r_dv_hr[k];
                r_dv_a[k+1]  <= r_dv_a[k];
                r_dv_ws[k+1] <= r_dv_ws[k];
                r_dv_we[k+1] <= r_dv_we[k];
            end
        end
    end

    // ---------------- stage 11: floor, saturate, clear when no roots
    logic r11_vld, r11_hr;
    logic signed [RW-1:0] r11_t [0:1];
    logic signed [RW-1:0] n11_t [0:1];
    logic [WW-1:0] r11_ws, r11_we;

    always_comb begin
        logic [QB-1:0] q;
        logic [QB:0] qq;
        for (int g = 0; g < 2; g++) begin
            q  = r_dv_q[g][QB];
            qq = {1'b0, q} + (QB+1)'(r_dv_rem[g][QB] != '0);
            if (!r_dv_hr[QB]) begin
                n11_t[g] = '0;
            end else if (!r_dv_neg[g][QB]) begin
                if (r_dv_ovf[g][QB] || (q[QB-1:RW-1] != '0)) begin
                    n11_t[g] = srcht_pkg::ROOT_MAX;
                end else begin
                    n11_t[g] = signed'(q[RW-1:0]);
                end
            end else begin
                // magnitude of exactly 2^31 still fits as the most negative value
                if (r_dv_ovf[g][QB] || (qq > ((QB+1)'(1) << (RW-1)))) begin
                    n11_t[g] = srcht_pkg::ROOT_MIN;
                end else begin
                    n11_t[g] = -signed'(qq[RW-1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (en) begin
            r11_vld <= r_dv_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_hr   <= r_dv_hr[QB];
            r11_t[0] <= n11_t[0];
            r11_t[1] <= n11_t[1];
            r11_ws   <= r_dv_ws[QB];
            r11_we   <= r_dv_we[QB];
        end
    end

    // ---------------- stage 12: window test and output register
    logic r_out_vld, r_hit, r_hr;
    logic signed [RW-1:0] r_tn, r_tf;
    logic n_hit;
    logic signed [RW:0] ws_ext, we_ext, tn_ext, tf_ext;

    assign ws_ext = (RW+1)'(signed'({1'b0, r11_ws}));
    assign we_ext = (RW+1)'(signed'({1'b0, r11_we}));
    assign tn_ext = (RW+1)'(r11_t[0]);
    assign tf_ext = (RW+1)'(r11_t[1]);
    assign n_hit  = r11_hr && (((tn_ext > ws_ext) && (tn_ext < we_ext))
                            || ((tf_ext > ws_ext) && (tf_ext < we_ext)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_hr  <= r11_hr;
            r_tn  <= r11_t[0];
            r_tf  <= r11_t[1];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'({r_tf, r_tn, r_hr, r_hit});

    // ---------------- checks
    a_hit_needs_roots : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_hit |-> r_hr)
        else $error("hit reported without roots");

    a_no_roots_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_hr |-> (r_tn == '0) && (r_tf == '0))
        else $error("roots not cleared when there are none");

    a_roots_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_hr |-> r_tn <= r_tf)
        else $error("near root above far root");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r11_vld) && $stable(r_dv_vld[0]))
        else $error("pipeline moved during stall");

endmodule
